/* rtl/arp_responder_with_cache_core_assert.svh */
// Assertion macros for the ARP responder core
`ifndef ARP_RESPONDER_WITH_CACHE_CORE_ASSERT_SVH
`define ARP_RESPONDER_WITH_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ARPC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arpc: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ARPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arpc: next-cycle check failed");

`endif

/* rtl/arpc_pkg.sv */
// Shared types, constants and reply-frame builder for the ARP responder
`timescale 1ns / 1ps
package arpc_pkg;

  localparam int CACHE_ENTRIES     = 256;
  localparam int CACHE_AW          = $clog2(CACHE_ENTRIES);
  localparam int REPLY_FRAME_BYTES = 64;
  localparam int REPLY_WORDS       = REPLY_FRAME_BYTES / 8;
  localparam int WORD_IDX_W        = $clog2(REPLY_WORDS);
  localparam int QDEPTH            = 2;
  localparam int Q_AW              = $clog2(QDEPTH);
  localparam int Q_CW              = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 48;

  localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
  localparam logic [55:0] ARP_FIXED_HDR = 56'h00010800060400;
  localparam logic [7:0]  OPC_REQUEST   = 8'h01;
  localparam logic [7:0]  OPC_REPLY     = 8'h02;
  localparam logic [7:0]  HOST_BCAST    = 8'hff;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NET_MASK   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NET_PREFIX = 2'd3;

  typedef enum logic [2:0] {
    ST_REPLY   = 3'd0,
    ST_DONE    = 3'd1,
    ST_BAD_HDR = 3'd2,
    ST_BAD_OP  = 3'd3,
    ST_NOT_ARP = 3'd4,
    ST_LOOKUP  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    OP_STATUS,
    OP_LOOKUP,
    OP_REPLY
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOK,
    BK_WORDS
  } bk_state_t;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [31:0] net_mask;
    logic [31:0] net_prefix;
  } cfg_t;

  // One classified item as queued between front and back
  typedef struct packed {
    op_t                 op;
    logic                learn;
    status_t             status;
    logic [CACHE_AW-1:0] host;
    logic [47:0]         dst_mac;
    logic [47:0]         snd_mac;
    logic [31:0]         snd_ip;
  } cmd_t;

  function automatic logic [63:0] reply_word(input logic [WORD_IDX_W-1:0] idx,
                                             input cmd_t c, input cfg_t g);
    logic [63:0] w;
    begin
      case (idx)
        3'd0:    w = {c.dst_mac, g.own_mac[47:32]};
        3'd1:    w = {g.own_mac[31:0], ETHERTYPE_ARP, ARP_FIXED_HDR[55:40]};
        3'd2:    w = {ARP_FIXED_HDR[39:0], OPC_REPLY, g.own_mac[47:32]};
        3'd3:    w = {g.own_mac[31:0], g.own_ip};
        3'd4:    w = {c.snd_mac, c.snd_ip[31:16]};
        3'd5:    w = {c.snd_ip[15:0], 48'h0};
        default: w = 64'h0;
      endcase
      return w;
    end
  endfunction

endpackage

/* rtl/arpc_if.sv */
// Input and result channel interfaces for the ARP responder
`timescale 1ns / 1ps
interface arpc_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [47:0] eth_src_mac;
  logic [15:0] ethertype;
  logic [55:0] arp_header;
  logic [7:0]  arp_opcode_low;
  logic [47:0] sender_mac;
  logic [31:0] sender_ip;
  logic [31:0] target_ip;
  logic [7:0]  lookup_host;

  modport source (output valid, req_type, eth_src_mac, ethertype, arp_header,
                  arp_opcode_low, sender_mac, sender_ip, target_ip, lookup_host,
                  input ready);
  modport sink (input valid, req_type, eth_src_mac, ethertype, arp_header,
                arp_opcode_low, sender_mac, sender_ip, target_ip, lookup_host,
                output ready);
endinterface

interface arpc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] frame_word;
  logic [47:0] lookup_mac;
  logic        last;

  modport source (output valid, status, frame_word, lookup_mac, last, input ready);
  modport sink (input valid, status, frame_word, lookup_mac, last, output ready);
endinterface

/* rtl/arp_responder_with_cache_core.sv */
// ARP responder with a 256-entry gleaned address cache. Each input beat is
// either the parsed ARP fields of a received frame or a MAC lookup for a host
// octet. A request for our IP answers with a 64-byte reply frame of eight
// 64-bit words, one word per cycle from the output register while it is not
// stalled; other frames give one status beat loaded on dequeue, and a lookup
// reads the cache memory through its registered read port first. A two-entry
// command queue sits between the classifier and the executor. The cache reads
// as zero after reset through per-entry valid bits, so no clearing pass is
// needed. Registers must be written on the cfg port only while the block is
// idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`include "arp_responder_with_cache_core_assert.svh"
module arp_responder_with_cache_core (
  input  logic                               clk,
  input  logic                               rst_n,
  arpc_in_if.sink                            in_ch,
  arpc_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import arpc_pkg::*;

  cfg_t cfg_r;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_cmd;
  cmd_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_MAC:    cfg_r.own_mac    <= cfg_data[47:0];
        CFG_OWN_IP:     cfg_r.own_ip     <= cfg_data[31:0];
        CFG_NET_MASK:   cfg_r.net_mask   <= cfg_data[31:0];
        CFG_NET_PREFIX: cfg_r.net_prefix <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  arpc_front u_front (
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  arpc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  arpc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // only reply words may leave without last
  `ARPC_ASSERT_SAME(a_single_beat_last, out_ch.valid && (out_ch.status != ST_REPLY), out_ch.last)
  // frame data only on reply words
  `ARPC_ASSERT_SAME(a_word_zero, out_ch.valid && (out_ch.status != ST_REPLY), out_ch.frame_word == 64'h0)
  // cached MAC only on lookup results
  `ARPC_ASSERT_SAME(a_mac_zero, out_ch.valid && (out_ch.status != ST_LOOKUP), out_ch.lookup_mac == 48'h0)
  // a reply keeps the executor busy, so no back-to-back dequeue
  `ARPC_ASSERT_NEXT(a_reply_busy, q_pop && (q_head.op == OP_REPLY), !q_pop)

endmodule

/* rtl/arpc_fifo.sv */
// Short command queue between the classifier and the executor
`timescale 1ns / 1ps
module arpc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  arpc_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output arpc_pkg::cmd_t head,
  output logic           empty
);
  import arpc_pkg::*;

  cmd_t            mem_r [QDEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] cnt_r;
  logic [Q_CW-1:0] cnt_nxt;

  assign full  = (cnt_r == Q_CW'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/arpc_front.sv */
// Front end: accepts input beats, checks the ARP frame and queues a command
`timescale 1ns / 1ps
module arpc_front (
  arpc_in_if.sink        in_ch,
  input  arpc_pkg::cfg_t cfg,
  input  logic           q_full,
  output logic           q_push,
  output arpc_pkg::cmd_t q_cmd
);
  import arpc_pkg::*;

  logic glean_ok;
  logic for_us;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // Learn only unicast hosts of our own subnet
  assign glean_ok = (in_ch.sender_ip != 32'h0) &&
                    (in_ch.sender_ip[7:0] != HOST_BCAST) &&
                    ((in_ch.sender_ip & cfg.net_mask) == cfg.net_prefix);
  assign for_us   = (in_ch.arp_opcode_low == OPC_REQUEST) &&
                    (in_ch.target_ip == cfg.own_ip);

  always_comb begin
    q_cmd         = '0;
    q_cmd.op      = OP_STATUS;
    q_cmd.status  = ST_DONE;
    q_cmd.host    = in_ch.sender_ip[CACHE_AW-1:0];
    q_cmd.dst_mac = in_ch.eth_src_mac;
    q_cmd.snd_mac = in_ch.sender_mac;
    q_cmd.snd_ip  = in_ch.sender_ip;
    if (in_ch.req_type) begin
      q_cmd.op     = OP_LOOKUP;
      q_cmd.status = ST_LOOKUP;
      q_cmd.host   = in_ch.lookup_host[CACHE_AW-1:0];
    end else if (in_ch.ethertype != ETHERTYPE_ARP) begin
      q_cmd.status = ST_NOT_ARP;
    end else if (in_ch.arp_header != ARP_FIXED_HDR) begin
      q_cmd.status = ST_BAD_HDR;
    end else if (!(in_ch.arp_opcode_low inside {OPC_REQUEST, OPC_REPLY})) begin
      q_cmd.status = ST_BAD_OP;
    end else begin
      q_cmd.learn = glean_ok;
      if (for_us) begin
        q_cmd.op     = OP_REPLY;
        q_cmd.status = ST_REPLY;
      end
    end
  end

endmodule

/* rtl/arpc_back.sv */
// Back end: updates the address cache, answers lookups, streams reply words
`timescale 1ns / 1ps
module arpc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  arpc_pkg::cfg_t cfg,
  input  arpc_pkg::cmd_t head,
  input  logic           q_empty,
  output logic           q_pop,
  arpc_out_if.source     out_ch
);
  import arpc_pkg::*;

  bk_state_t             state_r;
  bk_state_t             state_nxt;
  logic [WORD_IDX_W-1:0] word_idx_r;
  logic [WORD_IDX_W-1:0] word_idx_nxt;
  cmd_t                  cur_r;

  logic [47:0]              cache_mem [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] vld_r;
  logic [47:0]              rd_data_r;
  logic                     rd_vld_r;
  logic                     rd_en;
  logic                     wr_en;

  logic        out_valid_r;
  logic        out_valid_nxt;
  status_t     out_status_r;
  logic [63:0] out_word_r;
  logic [47:0] out_mac_r;
  logic        out_last_r;

  logic        load_ok;
  logic        load;
  status_t     ld_status;
  logic [63:0] ld_word;
  logic [47:0] ld_mac;
  logic        ld_last;

  assign load_ok = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.frame_word = out_word_r;
  assign out_ch.lookup_mac = out_mac_r;
  assign out_ch.last       = out_last_r;

  always_comb begin
    state_nxt    = state_r;
    word_idx_nxt = word_idx_r;
    q_pop        = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    load         = 1'b0;
    ld_status    = ST_DONE;
    ld_word      = 64'h0;
    ld_mac       = 48'h0;
    ld_last      = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty && load_ok) begin
          q_pop = 1'b1;
          wr_en = head.learn;
          case (head.op)
            OP_LOOKUP: begin
              rd_en     = 1'b1;
              state_nxt = BK_LOOK;
            end
            OP_REPLY: begin
              // first word goes out with the pop, the rest from the saved command
              load         = 1'b1;
              ld_status    = ST_REPLY;
              ld_word      = reply_word('0, head, cfg);
              word_idx_nxt = WORD_IDX_W'(1);
              state_nxt    = BK_WORDS;
            end
            default: begin
              load      = 1'b1;
              ld_status = head.status;
              ld_last   = 1'b1;
            end
          endcase
        end
      end
      BK_LOOK: begin
        if (load_ok) begin
          load      = 1'b1;
          ld_status = ST_LOOKUP;
          ld_mac    = rd_vld_r ? rd_data_r : 48'h0;
          ld_last   = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      BK_WORDS: begin
        if (load_ok) begin
          load         = 1'b1;
          ld_status    = ST_REPLY;
          ld_word      = reply_word(word_idx_r, cur_r, cfg);
          ld_last      = (word_idx_r == WORD_IDX_W'(REPLY_WORDS - 1));
          word_idx_nxt = word_idx_r + 1'b1;
          if (ld_last) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      word_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      word_idx_r <= word_idx_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        vld_r[head.host] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= ld_status;
      out_word_r   <= ld_word;
      out_mac_r    <= ld_mac;
      out_last_r   <= ld_last;
    end
    if (q_pop) begin
      cur_r <= head;
    end
  end

  // Cache storage; an entry never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cache_mem[head.host] <= head.snd_mac;
    end
    if (rd_en) begin
      rd_data_r <= cache_mem[head.host];
      rd_vld_r  <= vld_r[head.host];
    end
  end

endmodule

/* tb/arp_responder_with_cache_core_checker.sv */
// Scoreboard for the ARP responder: mirrors the cache, predicts each result beat and compares
`timescale 1ns / 1ps
module arp_responder_with_cache_core_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  arpc_in_if                               in_mon,
  arpc_out_if                              out_mon,
  input  logic                             cfg_we,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int unsigned                      mismatches,
  output int unsigned                      backlog
);
  import arpc_pkg::*;

  typedef struct {
    status_t     status;
    logic [63:0] word;
    logic [47:0] mac;
    logic        last;
  } result_beat_t;

  logic [47:0]  station_mac;
  logic [31:0]  station_ip;
  logic [31:0]  subnet_mask;
  logic [31:0]  subnet_prefix;
  logic [47:0]  mac_cache [CACHE_ENTRIES];
  result_beat_t due_beats [$];
  int unsigned  bad_count;

  function automatic result_beat_t status_beat(input status_t st);
    result_beat_t b;
    b.status = st;
    b.word   = '0;
    b.mac    = '0;
    b.last   = 1'b1;
    return b;
  endfunction

  // Work out the beats one accepted input causes and update the mirrored cache
  task automatic answer_arp();
    result_beat_t b;
    logic [511:0] reply;
    logic [31:0]  sip;
    int           k;
    sip = in_mon.sender_ip;
    if (in_mon.req_type) begin
      b = status_beat(ST_LOOKUP);
      b.mac = mac_cache[in_mon.lookup_host];
      due_beats.push_back(b);
    end else if (in_mon.ethertype != ETHERTYPE_ARP) begin
      due_beats.push_back(status_beat(ST_NOT_ARP));
    end else if (in_mon.arp_header != ARP_FIXED_HDR) begin
      due_beats.push_back(status_beat(ST_BAD_HDR));
    end else if (in_mon.arp_opcode_low != OPC_REQUEST && in_mon.arp_opcode_low != OPC_REPLY) begin
      due_beats.push_back(status_beat(ST_BAD_OP));
    end else begin
      if (sip != 32'h0 && sip[7:0] != HOST_BCAST && (sip & subnet_mask) == subnet_prefix)
        mac_cache[sip[7:0]] = in_mon.sender_mac;
      if (in_mon.arp_opcode_low != OPC_REQUEST || in_mon.target_ip != station_ip) begin
        due_beats.push_back(status_beat(ST_DONE));
      end else begin
        // 42 bytes of header and payload, zero padded to 64
        reply = {in_mon.eth_src_mac, station_mac, ETHERTYPE_ARP, ARP_FIXED_HDR, OPC_REPLY,
                 station_mac, station_ip, in_mon.sender_mac, sip, 176'h0};
        for (k = 0; k < REPLY_WORDS; k++) begin
          b = status_beat(ST_REPLY);
          b.word = reply[511 - 64 * k -: 64];
          b.last = (k == REPLY_WORDS - 1);
          due_beats.push_back(b);
        end
      end
    end
  endtask

  task automatic check_beat();
    result_beat_t b;
    if (due_beats.size() == 0) begin
      bad_count++;
      if (bad_count <= 10)
        $display("%0t: unexpected result beat: status %0d frame_word %h lookup_mac %h last %b",
                 $realtime, out_mon.status, out_mon.frame_word, out_mon.lookup_mac, out_mon.last);
    end else begin
      b = due_beats.pop_front();
      if (out_mon.status !== b.status || out_mon.frame_word !== b.word ||
          out_mon.lookup_mac !== b.mac || out_mon.last !== b.last) begin
        bad_count++;
        if (bad_count <= 10)
          $display("%0t: result mismatch: status %0d/%0d frame_word %h/%h lookup_mac %h/%h last %b/%b (expected/actual)",
                   $realtime, b.status, out_mon.status, b.word, out_mon.frame_word,
                   b.mac, out_mon.lookup_mac, b.last, out_mon.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      station_mac   = '0;
      station_ip    = '0;
      subnet_mask   = '0;
      subnet_prefix = '0;
      foreach (mac_cache[i]) mac_cache[i] = '0;
      due_beats.delete();
      bad_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OWN_MAC:    station_mac   = cfg_data[47:0];
          CFG_OWN_IP:     station_ip    = cfg_data[31:0];
          CFG_NET_MASK:   subnet_mask   = cfg_data[31:0];
          CFG_NET_PREFIX: subnet_prefix = cfg_data[31:0];
          default: ;
        endcase
      end
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) check_beat();
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) answer_arp();
    end
    backlog    <= due_beats.size();
    mismatches <= bad_count;
  end

endmodule

/* tb/arp_responder_with_cache_core_tb.sv */
// Top of the ARP responder testbench: clock, reset, register setup, stimulus and verdict
`timescale 1ns / 1ps
module arp_responder_with_cache_core_tb;
  import arpc_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int LONG_HOLD      = 300;

  typedef struct {
    logic        req_type;
    logic [47:0] eth_src;
    logic [15:0] etype;
    logic [55:0] hdr;
    logic [7:0]  opcode;
    logic [47:0] smac;
    logic [31:0] sip;
    logic [31:0] tip;
    logic [7:0]  host;
  } arp_item_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned fail_count;
  int unsigned backlog;
  int unsigned hold_reqs = 0;

  logic [31:0] my_ip;
  logic [31:0] my_mask;
  logic [31:0] my_prefix;
  bit          steady;
  int unsigned burst_left;

  arpc_in_if  in_bus ();
  arpc_out_if out_bus ();

  arp_responder_with_cache_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  arp_responder_with_cache_core_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (fail_count),
    .backlog    (backlog)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(0, 65535)), 32'($urandom())};
  endfunction

  // Mostly a small pool of hosts so lookups hit learned entries
  function automatic logic [7:0] pick_host();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(1, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] subnet_ip(input logic [7:0] host);
    logic [31:0] ip;
    ip = (my_prefix & my_mask) | (32'($urandom()) & ~my_mask);
    if (my_mask[7:0] == 8'h0) ip[7:0] = host;
    return ip;
  endfunction

  function automatic arp_item_t frame_item(input logic [7:0] op, input logic [31:0] sip,
                                           input logic [31:0] tip);
    arp_item_t it;
    it.req_type = 1'b0;
    it.eth_src  = rand48();
    it.etype    = ETHERTYPE_ARP;
    it.hdr      = ARP_FIXED_HDR;
    it.opcode   = op;
    it.smac     = rand48();
    it.sip      = sip;
    it.tip      = tip;
    it.host     = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Frame fields of a lookup carry junk, the block ignores them
  function automatic arp_item_t lookup_item(input logic [7:0] host);
    arp_item_t it;
    it = frame_item(8'($urandom_range(0, 255)), 32'($urandom()), 32'($urandom()));
    if ($urandom_range(0, 1)) it.etype = 16'($urandom_range(0, 65535));
    it.hdr      = {24'($urandom()), 32'($urandom())};
    it.req_type = 1'b1;
    it.host     = host;
    return it;
  endfunction

  function automatic arp_item_t random_item();
    arp_item_t   it;
    int unsigned roll;
    logic [31:0] sip;
    roll = $urandom_range(0, 99);
    sip = ($urandom_range(0, 4) != 0) ? subnet_ip(pick_host()) : 32'($urandom());
    if ($urandom_range(0, 40) == 0) sip = 32'h0;
    if (roll < 35) begin
      it = frame_item(OPC_REQUEST, sip, my_ip);
    end else if (roll < 47) begin
      it = frame_item(OPC_REQUEST, sip, 32'($urandom()));
    end else if (roll < 60) begin
      it = frame_item(OPC_REPLY, sip, ($urandom_range(0, 1)) ? my_ip : 32'($urandom()));
    end else if (roll < 78) begin
      it = lookup_item(pick_host());
    end else if (roll < 83) begin
      it = frame_item(OPC_REQUEST, sip, my_ip);
      it.etype = ($urandom_range(0, 1)) ? 16'h0800 : 16'($urandom_range(0, 65535));
      if (it.etype == ETHERTYPE_ARP) it.etype = 16'h0800;
    end else if (roll < 88) begin
      it = frame_item(OPC_REQUEST, sip, my_ip);
      it.hdr = it.hdr ^ (56'h1 << $urandom_range(0, 55));
    end else if (roll < 93) begin
      it = frame_item(OPC_REQUEST, sip, my_ip);
      it.opcode = 8'($urandom_range(0, 255));
      if (it.opcode == OPC_REQUEST || it.opcode == OPC_REPLY) it.opcode = it.opcode + 8'd2;
    end else begin
      it = lookup_item(8'($urandom_range(0, 255)));
      it.req_type = 1'($urandom_range(0, 1));
      it.etype    = ($urandom_range(0, 1)) ? ETHERTYPE_ARP : 16'($urandom_range(0, 65535));
      it.sip      = 32'($urandom());
      it.tip      = 32'($urandom());
    end
    return it;
  endfunction

  // Offer one beat and hold it until accepted, then idle between bursts
  task automatic send(input arp_item_t it);
    int unsigned gap;
    in_bus.valid          <= 1'b1;
    in_bus.req_type       <= it.req_type;
    in_bus.eth_src_mac    <= it.eth_src;
    in_bus.ethertype      <= it.etype;
    in_bus.arp_header     <= it.hdr;
    in_bus.arp_opcode_low <= it.opcode;
    in_bus.sender_mac     <= it.smac;
    in_bus.sender_ip      <= it.sip;
    in_bus.target_ip      <= it.tip;
    in_bus.lookup_host    <= it.host;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [47:0] mac, input logic [31:0] ip,
                            input logic [31:0] mask, input logic [31:0] prefix);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OWN_MAC;
    cfg_data  <= mac;
    @(posedge clk);
    cfg_index <= CFG_OWN_IP;
    cfg_data  <= {16'h0, ip};
    @(posedge clk);
    cfg_index <= CFG_NET_MASK;
    cfg_data  <= {16'h0, mask};
    @(posedge clk);
    cfg_index <= CFG_NET_PREFIX;
    cfg_data  <= {16'h0, prefix};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    my_ip     = ip;
    my_mask   = mask;
    my_prefix = prefix;
  endtask

  task automatic random_config();
    int unsigned plen;
    logic [31:0] mask;
    logic [31:0] prefix;
    logic [47:0] mac;
    logic [31:0] ip;
    plen   = $urandom_range(0, 32);
    mask   = (plen == 0) ? 32'h0 : (32'hffff_ffff << (32 - plen));
    prefix = ($urandom_range(0, 5) == 0) ? 32'($urandom()) : (32'($urandom()) & mask);
    case ($urandom_range(0, 4))
      0:       mac = '0;
      1:       mac = '1;
      default: mac = rand48();
    endcase
    ip = ($urandom_range(0, 4) == 0) ? 32'h0 : (prefix & mask) | (32'($urandom()) & ~mask);
    set_config(mac, ip, mask, prefix);
  endtask

  // Receiver: changing stall pattern, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned served;
    int unsigned tick;
    int unsigned mode;
    hold_left = 0;
    served    = 0;
    tick      = 0;
    mode      = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 96 == 0) mode = $urandom_range(0, 3);
      if (served != hold_reqs) begin
        served    = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= 1'($urandom_range(0, 1));
          2:       out_bus.ready <= ($urandom_range(0, 6) != 0);
          default: out_bus.ready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("** arp_responder_with_cache_core: FAILED **");
    $finish;
  end

  initial begin
    arp_item_t it;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= CFG_OWN_MAC;
    cfg_data              <= '0;
    in_bus.valid          <= 1'b0;
    in_bus.req_type       <= 1'b0;
    in_bus.eth_src_mac    <= '0;
    in_bus.ethertype      <= '0;
    in_bus.arp_header     <= '0;
    in_bus.arp_opcode_low <= '0;
    in_bus.sender_mac     <= '0;
    in_bus.sender_ip      <= '0;
    in_bus.target_ip      <= '0;
    in_bus.lookup_host    <= '0;
    my_ip      = '0;
    my_mask    = '0;
    my_prefix  = '0;
    steady     = 1'b0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at reset: own IP zero, every nonzero sender whose host octet is not ff learns
    send(lookup_item(8'h00));
    send(frame_item(OPC_REQUEST, 32'h0, 32'h0));
    send(frame_item(OPC_REPLY, 32'h0a0000ff, 32'h0));
    send(lookup_item(8'hff));
    send(lookup_item(8'h00));
    it = frame_item(OPC_REPLY, 32'hc0a80101, 32'h0);
    it.smac = '1;
    send(it);
    send(lookup_item(8'h01));
    drain();

    set_config(48'h02_00_5e_10_20_30, 32'hc0a80a05, 32'hffffff00, 32'hc0a80a00);
    send(frame_item(OPC_REQUEST, 32'hc0a80a07, my_ip));
    send(lookup_item(8'h07));
    send(frame_item(OPC_REQUEST, 32'hc0a80a09, 32'hc0a80a63));
    send(frame_item(OPC_REPLY, 32'hc0a80b0b, my_ip));
    send(lookup_item(8'h0b));
    it = frame_item(OPC_REQUEST, 32'hc0a80a0c, my_ip);
    it.etype = 16'h0800;
    send(it);
    it.etype = 16'hffff;
    send(it);
    it = frame_item(OPC_REQUEST, 32'hc0a80a0c, my_ip);
    it.hdr = '1;
    send(it);
    it.hdr = ARP_FIXED_HDR | 56'h1;
    send(it);
    it = frame_item(8'h00, 32'hc0a80a0c, my_ip);
    send(it);
    it.opcode = 8'h03;
    send(it);
    it.opcode = 8'hff;
    send(it);
    it = frame_item(OPC_REQUEST, 32'hc0a80aff, my_ip);
    it.eth_src = '1;
    it.smac    = '1;
    send(it);
    send(lookup_item(8'hff));
    it = frame_item(OPC_REQUEST, 32'hc0a80a07, my_ip);
    it.eth_src = '0;
    it.smac    = '0;
    send(it);
    send(lookup_item(8'h07));
    drain();

    // Back-pressure: receiver holds off while requests for us keep coming
    hold_reqs <= hold_reqs + 1;
    steady = 1'b1;
    repeat (20) send(frame_item(OPC_REQUEST, subnet_ip(pick_host()), my_ip));
    steady = 1'b0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       set_config('1, 32'hffffffff, 32'hffffffff, 32'hc0a80a11);
        1:       set_config('0, 32'h0, 32'h0, 32'h0);
        default: random_config();
      endcase
      steady = (ph % 3 == 2);
      repeat (70) send(random_item());
      steady = 1'b0;
      drain();
    end

    repeat (16) @(posedge clk);
    if (fail_count == 0 && backlog == 0)
      $display("** arp_responder_with_cache_core: PASSED **");
    else
      $display("** arp_responder_with_cache_core: FAILED **");
    $finish;
  end

endmodule
